// ===== hdl/wrf_pkg.sv =====
package wrf_pkg;

    // Window geometry
    localparam int NWINDOWS     = 8;
    localparam int WINDOW_WIDTH = 16;
    localparam int CWP_W        = 5;
    localparam int WIN_BITS     = (NWINDOWS > 1) ? $clog2(NWINDOWS) : 1;
    localparam int OFF_BITS     = $clog2(WINDOW_WIDTH);
    localparam int STORE_DEPTH  = NWINDOWS * WINDOW_WIDTH;
    localparam int STORE_AW     = $clog2(STORE_DEPTH);

    // Status word constants
    localparam logic [31:0] PSR_RESET = 32'hF300_0080;
    localparam logic [31:0] TBR_KEEP  = 32'hFFFF_F000;
    localparam int          S_BIT_POS = 7;

    // Commands
    localparam logic [2:0] CMD_READ    = 3'd0;
    localparam logic [2:0] CMD_WRITE   = 3'd1;
    localparam logic [2:0] CMD_SAVE    = 3'd2;
    localparam logic [2:0] CMD_RESTORE = 3'd3;
    localparam logic [2:0] CMD_WDEC    = 3'd4;

    // Register classes
    localparam logic [3:0] CLS_G   = 4'd0;
    localparam logic [3:0] CLS_O   = 4'd1;
    localparam logic [3:0] CLS_L   = 4'd2;
    localparam logic [3:0] CLS_I   = 4'd3;
    localparam logic [3:0] CLS_F   = 4'd4;
    localparam logic [3:0] CLS_ASR = 4'd5;
    localparam logic [3:0] CLS_PSR = 4'd6;
    localparam logic [3:0] CLS_FSR = 4'd7;
    localparam logic [3:0] CLS_WIM = 4'd8;
    localparam logic [3:0] CLS_TBR = 4'd9;
    localparam logic [3:0] CLS_Y   = 4'd10;
    localparam logic [3:0] CLS_PC  = 4'd11;
    localparam logic [3:0] CLS_NPC = 4'd12;

    // Trap kinds
    localparam logic [2:0] TRAP_NONE  = 3'd0;
    localparam logic [2:0] TRAP_PRIV  = 3'd1;
    localparam logic [2:0] TRAP_CWP   = 3'd2;
    localparam logic [2:0] TRAP_OVER  = 3'd3;
    localparam logic [2:0] TRAP_UNDER = 3'd4;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  reg_class;
        logic [4:0]  reg_index;
        logic [31:0] write_value;
    } in_item_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic [2:0]  trap_kind;
        logic [4:0]  current_window;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic exec;
    } ctl_t;

endpackage

// ===== hdl/wrf_ram.sv =====
module wrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/wrf_ctrl.sv =====
module wrf_ctrl
    import wrf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    output ctl_t ctl,
    output logic result_valid
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg;

    // Advance: accept in idle, execute in the next cycle
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_EXEC);
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign ctl.capture  = start && (state_reg == ST_IDLE);
    assign ctl.exec     = (state_reg == ST_EXEC);
    assign result_valid = done_reg;

endmodule

// ===== hdl/wrf_datapath.sv =====
module wrf_datapath
    import wrf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ctl_t      ctl,
    input  in_item_t  item,
    output out_item_t result
);

    in_item_t             item_reg;
    out_item_t            res_reg;
    logic [STORE_AW-1:0]  waddr_reg;
    logic [STORE_DEPTH-1:0] wvalid_reg;
    logic [31:0]          glb_reg [8];
    logic [31:0]          flt_reg [32];
    logic [31:0]          anc_reg [32];
    logic [31:0]          psr_reg, fsr_reg, wim_reg, tbr_reg, y_reg, pc_reg, npc_reg;
    logic [31:0]          psr_next, fsr_next, wim_next, tbr_next, y_next, pc_next, npc_next;

    logic [CWP_W-1:0]     cwp, cwp_dn, cwp_up;
    logic [WIN_BITS-1:0]  win_sel;
    logic [OFF_BITS-1:0]  off_sel;
    logic [STORE_AW-1:0]  waddr_now;
    logic [31:0]          ram_rdata, win_rd;
    logic                 win_we, glb_we, flt_we, anc_we, sup;
    logic [31:0]          rd_val;
    logic [2:0]           trap;
    logic [2:0]           i3;

    assign cwp    = psr_reg[CWP_W-1:0];
    assign sup    = psr_reg[S_BIT_POS];
    assign cwp_dn = (cwp == '0) ? CWP_W'(NWINDOWS - 1) : cwp - 1'b1;
    assign cwp_up = (cwp >= CWP_W'(NWINDOWS - 1)) ? '0 : cwp + 1'b1;

    // Window slot for the incoming beat: outs live in the window below
    always_comb
    begin
        win_sel   = (item.reg_class == CLS_O) ? cwp_dn[WIN_BITS-1:0] : cwp[WIN_BITS-1:0];
        off_sel   = OFF_BITS'({(item.reg_class == CLS_L), item.reg_index[2:0]});
        waddr_now = STORE_AW'(STORE_AW'(win_sel) * STORE_AW'(WINDOW_WIDTH))
                    + STORE_AW'(off_sel);
    end

    wrf_ram #(
        .WIDTH (32),
        .DEPTH (STORE_DEPTH)
    ) u_win_ram (
        .clk     (clk),
        .wr_en   (win_we),
        .wr_addr (waddr_reg),
        .wr_data (item_reg.write_value),
        .rd_en   (ctl.capture),
        .rd_addr (waddr_now),
        .rd_data (ram_rdata)
    );

    assign win_rd = wvalid_reg[waddr_reg] ? ram_rdata : 32'd0;
    assign i3     = item_reg.reg_index[2:0];

    // Execute the held beat
    always_comb
    begin
        rd_val   = '0;
        trap     = TRAP_NONE;
        win_we   = 1'b0;
        glb_we   = 1'b0;
        flt_we   = 1'b0;
        anc_we   = 1'b0;
        psr_next = psr_reg;
        fsr_next = fsr_reg;
        wim_next = wim_reg;
        tbr_next = tbr_reg;
        y_next   = y_reg;
        pc_next  = pc_reg;
        npc_next = npc_reg;
        if (ctl.exec)
        begin
            case (item_reg.command)
                CMD_READ:
                begin
                    case (item_reg.reg_class)
                        CLS_G:   rd_val = (i3 == 3'd0) ? 32'd0 : glb_reg[i3];
                        CLS_O, CLS_L, CLS_I: rd_val = win_rd;
                        CLS_F:   rd_val = flt_reg[item_reg.reg_index];
                        CLS_ASR: rd_val = anc_reg[item_reg.reg_index];
                        CLS_PSR: rd_val = psr_reg;
                        CLS_FSR: rd_val = fsr_reg;
                        CLS_WIM: rd_val = wim_reg;
                        CLS_TBR: rd_val = tbr_reg;
                        CLS_Y:   rd_val = y_reg;
                        CLS_PC:  rd_val = pc_reg;
                        CLS_NPC: rd_val = npc_reg;
                        default: rd_val = '0;
                    endcase
                end
                CMD_WRITE:
                begin
                    case (item_reg.reg_class)
                        CLS_G:   glb_we = (i3 != 3'd0);
                        CLS_O, CLS_L, CLS_I: win_we = 1'b1;
                        CLS_F:   flt_we = 1'b1;
                        CLS_ASR: anc_we = 1'b1;
                        CLS_PSR:
                        begin
                            if (!sup)
                                trap = TRAP_PRIV;
                            else if ({1'b0, item_reg.write_value[4:0]} >= 6'(NWINDOWS))
                                trap = TRAP_CWP;
                            else
                                psr_next = item_reg.write_value;
                        end
                        CLS_FSR: fsr_next = item_reg.write_value;
                        CLS_WIM:
                        begin
                            if (!sup) trap = TRAP_PRIV;
                            else      wim_next = item_reg.write_value;
                        end
                        CLS_TBR:
                        begin
                            if (!sup) trap = TRAP_PRIV;
                            else      tbr_next = item_reg.write_value & TBR_KEEP;
                        end
                        CLS_Y:   y_next   = item_reg.write_value;
                        CLS_PC:  pc_next  = item_reg.write_value;
                        CLS_NPC: npc_next = item_reg.write_value;
                        default: ;
                    endcase
                end
                CMD_SAVE:
                begin
                    if (wim_reg[cwp_dn]) trap = TRAP_OVER;
                    else psr_next = {psr_reg[31:CWP_W], cwp_dn};
                end
                CMD_RESTORE:
                begin
                    if (wim_reg[cwp_up]) trap = TRAP_UNDER;
                    else psr_next = {psr_reg[31:CWP_W], cwp_up};
                end
                CMD_WDEC: psr_next = {psr_reg[31:CWP_W], cwp_dn};
                default: ;
            endcase
        end
    end

    // Capture the beat and window address
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            item_reg  <= item;
            waddr_reg <= waddr_now;
        end
        if (ctl.exec)
        begin
            res_reg.read_value     <= rd_val;
            res_reg.trap_kind      <= trap;
            res_reg.current_window <= psr_next[CWP_W-1:0];
        end
    end

    // Architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wvalid_reg <= '0;
            for (int k = 0; k < 8; k++)
            begin
                glb_reg[k] <= '0;
            end
            for (int k = 0; k < 32; k++)
            begin
                flt_reg[k] <= '0;
                anc_reg[k] <= '0;
            end
            psr_reg <= PSR_RESET;
            fsr_reg <= '0;
            wim_reg <= '0;
            tbr_reg <= '0;
            y_reg   <= '0;
            pc_reg  <= '0;
            npc_reg <= 32'd4;
        end
        else
        begin
            if (win_we)
                wvalid_reg[waddr_reg] <= 1'b1;
            if (glb_we)
                glb_reg[i3] <= item_reg.write_value;
            if (flt_we)
                flt_reg[item_reg.reg_index] <= item_reg.write_value;
            if (anc_we)
                anc_reg[item_reg.reg_index] <= item_reg.write_value;
            psr_reg <= psr_next;
            fsr_reg <= fsr_next;
            wim_reg <= wim_next;
            tbr_reg <= tbr_next;
            y_reg   <= y_next;
            pc_reg  <= pc_next;
            npc_reg <= npc_next;
        end
    end

    assign result = res_reg;

endmodule

// ===== hdl/windowed_register_file_unit.sv =====
// Windowed register file with status registers.
// Input channel: drive item and raise start; the beat is taken at a rising
// edge where start is high and busy is low. Commands read or write one
// register, or move the current window (save, restore, unchecked decrement).
// Output channel: result_valid pulses for one cycle with result holding the
// read value, trap kind and the window pointer after the command. The
// receiver cannot stall; it must take the beat in that cycle.
// Timing: the result and result_valid are registered at the edge that
// ends the execute cycle. A new command is not taken while one executes.
// The window store is a memory with a registered read, so the
// accepting edge fetches the window slot and the next cycle executes and
// updates state. busy is high during the execute cycle only.
// Reset: all stores clear, the status word loads supervisor mode with window
// zero, and nPC loads four. The window store needs no clearing pass: each
// slot carries a valid flag that reset clears, and an unwritten slot reads
// as zero.
module windowed_register_file_unit
    import wrf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  item,
    output logic      result_valid,
    output out_item_t result
);

    ctl_t ctl;

    wrf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .ctl          (ctl),
        .result_valid (result_valid)
    );

    wrf_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .item   (item),
        .result (result)
    );

endmodule
